@@ rtl/cdls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdls_pkg
// Shared types and constants of the current deadband level stepper.
// ----------------------------------------------------------------------------
package cdls_pkg;

  localparam int unsigned CUR_W   = 16;
  localparam int unsigned GOAL_W  = 14;
  localparam int unsigned DB_W    = 12;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned DATA_W  = 16;

  localparam logic [GOAL_W-1:0]  GOAL_MIN       = 14'd300;
  localparam logic [GOAL_W-1:0]  GOAL_MAX       = 14'd9000;
  localparam logic [GOAL_W-1:0]  GOAL_RST       = 14'd1000;
  localparam logic [DB_W-1:0]    DEADBAND_RST   = 12'd300;
  localparam logic [CUR_W-1:0]   TRIP_RST       = 16'd10500;
  localparam logic [CUR_W-1:0]   OFFSET_RST     = 16'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_RST      = 8'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_PROT_LIM = 8'd220;
  localparam logic [LEVEL_W-1:0] LEVEL_PROT_VAL = 8'd8;

  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_STEP      = 2'd1,
    ACT_SET_LEVEL = 2'd2,
    ACT_SET_MODE  = 2'd3
  } action_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ADC_OFFSET   = 8'd0,
    REG_CURRENT_GOAL = 8'd1,
    REG_DEADBAND     = 8'd2,
    REG_TRIP_CURRENT = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CUR_W-1:0]  adc_offset;
    logic [GOAL_W-1:0] current_goal;
    logic [DB_W-1:0]   deadband;
    logic [CUR_W-1:0]  trip_current;
  } cfg_t;

  typedef struct packed {
    logic [CUR_W-1:0]   present;
    logic [CUR_W-1:0]   filtered;
    logic [LEVEL_W-1:0] level;
    logic               auto_on;
  } state_t;

endpackage

@@ rtl/cdls_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdls_if
// Valid/ready channels of the current deadband level stepper.
// ----------------------------------------------------------------------------
interface cdls_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [cdls_pkg::CUR_W-1:0]          sample;
  logic                                resonance_idle;
  logic [cdls_pkg::LEVEL_W-1:0]        new_level;
  logic                                mode;

  modport source (output valid, action, sample, resonance_idle, new_level, mode,
                  input ready);
  modport sink   (input valid, action, sample, resonance_idle, new_level, mode,
                  output ready);
endinterface

interface cdls_out_if;
  logic                                valid;
  logic                                ready;
  logic [cdls_pkg::CUR_W-1:0]          filtered_current;
  logic [cdls_pkg::CUR_W-1:0]          present_current;
  logic [cdls_pkg::LEVEL_W-1:0]        level;
  logic                                level_changed;
  logic                                auto_on;

  modport source (output valid, filtered_current, present_current, level,
                  level_changed, auto_on, input ready);
  modport sink   (input valid, filtered_current, present_current, level,
                  level_changed, auto_on, output ready);
endinterface

interface cdls_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cdls_pkg::IDX_W-1:0]          index;
  logic [cdls_pkg::DATA_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/cdls_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdls_step
// Next-state logic for one transaction: filter, protection, stepper, manual level and mode.
// ----------------------------------------------------------------------------
module cdls_step #(
  parameter int unsigned LEVEL_MAX = 235
) (
  input  cdls_pkg::state_t                 cur,
  input  cdls_pkg::cfg_t                   cfg,
  input  cdls_pkg::action_t                action,
  input  logic [cdls_pkg::CUR_W-1:0]       sample,
  input  logic                             resonance_idle,
  input  logic [cdls_pkg::LEVEL_W-1:0]     new_level,
  input  logic                             mode,
  output cdls_pkg::state_t                 nxt,
  output logic                             changed
);

  localparam logic [cdls_pkg::LEVEL_W-1:0] LMAX = cdls_pkg::LEVEL_W'(LEVEL_MAX);

  logic [cdls_pkg::CUR_W-1:0]   present_new;
  logic [cdls_pkg::CUR_W+2:0]   filt_sum;
  logic [cdls_pkg::CUR_W-1:0]   band_hi;
  logic [cdls_pkg::CUR_W:0]     cur_plus_db;
  logic                         step_dn;
  logic                         step_up;
  logic                         auto_chk;
  logic [cdls_pkg::LEVEL_W-1:0] level_prot;

  // (p*10 + f*70)/80 is exactly (p + 7f)/8
  assign present_new = (sample > cfg.adc_offset) ? sample - cfg.adc_offset : '0;
  assign filt_sum    = {3'b000, present_new} + {cur.filtered, 3'b000}
                     - {3'b000, cur.filtered};

  assign band_hi     = {2'b00, cfg.current_goal} + {4'b0000, cfg.deadband};
  assign cur_plus_db = {1'b0, cur.present} + {5'b00000, cfg.deadband};
  assign step_dn     = cur.present > band_hi;
  // cur <= goal - db, never true when the band reaches below zero
  assign step_up     = cur_plus_db <= {3'b000, cfg.current_goal};

  assign auto_chk    = cur.auto_on && !(cur.present > cfg.trip_current);
  assign level_prot  = (cur.level > cdls_pkg::LEVEL_PROT_LIM) ?
                       cdls_pkg::LEVEL_PROT_VAL : cur.level;

  always_comb begin
    nxt     = cur;
    changed = 1'b0;
    unique case (action)
      cdls_pkg::ACT_SAMPLE: begin
        nxt.present  = present_new;
        nxt.filtered = filt_sum[cdls_pkg::CUR_W+2:3];
      end
      cdls_pkg::ACT_STEP: begin
        nxt.auto_on = auto_chk;
        nxt.level   = level_prot;
        changed     = cur.level > cdls_pkg::LEVEL_PROT_LIM;
        if (auto_chk && resonance_idle) begin
          if (step_dn) begin
            if (level_prot != '0) nxt.level = level_prot - 1'b1;
            changed = 1'b1;
          end else if (step_up) begin
            if (level_prot < LMAX) nxt.level = level_prot + 1'b1;
            changed = 1'b1;
          end
        end
      end
      cdls_pkg::ACT_SET_LEVEL: begin
        nxt.level = (new_level > LMAX) ? LMAX : new_level;
        changed   = 1'b1;
      end
      cdls_pkg::ACT_SET_MODE: begin
        nxt.auto_on = mode;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

@@ rtl/current_deadband_level_stepper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_deadband_level_stepper
// Automatic transmitter current control with a deadband pulse-skip stepper.
// ----------------------------------------------------------------------------
// usage
//   in_if   : one transaction per item, action selects sample, control step,
//             manual level or mode write
//   out_if  : exactly one result transaction per input transaction, in order,
//             carrying the state as left by that item
//   cfg_if  : register writes (offset, goal, deadband, trip level), always
//             ready; the user must write only while the block is idle (not
//             enforced); goal clamped to 300..9000, unknown indexes dropped
// timing and throughput
//   the result appears in the cycle after acceptance, from the output register;
//   one item per cycle while out_if is ready, set by the single combinational
//   state update into the state registers, which also form the output register
// reset
//   synchronous active-low; level 5, currents 0, auto mode off, registers
//   at their defaults, output register empty
// stall
//   in_if.ready follows out_if: a new item is taken while the output register
//   is empty or being drained in the same cycle, so nothing is lost or doubled
// ----------------------------------------------------------------------------
module current_deadband_level_stepper #(
  parameter int unsigned LEVEL_MAX = 235
) (
  input  logic       clk,
  input  logic       rst_n,
  cdls_in_if.sink    in_if,
  cdls_out_if.source out_if,
  cdls_cfg_if.sink   cfg_if
);

  // configuration registers
  cdls_pkg::cfg_t   cfg_r;
  cdls_pkg::cfg_t   cfg_nxt;
  logic [cdls_pkg::GOAL_W-1:0] goal_wr;

  // control state and result register
  cdls_pkg::state_t st_r;
  cdls_pkg::state_t st_nxt;
  logic             changed_nxt;
  logic             changed_r;
  logic             out_valid_r;
  logic             in_fire;
  logic             cfg_fire;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;

  // goal clamp on write
  always_comb begin
    goal_wr = cfg_if.data[cdls_pkg::GOAL_W-1:0];
    if (goal_wr < cdls_pkg::GOAL_MIN) goal_wr = cdls_pkg::GOAL_MIN;
    if (goal_wr > cdls_pkg::GOAL_MAX) goal_wr = cdls_pkg::GOAL_MAX;
  end

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_fire) begin
      unique case (cdls_pkg::reg_idx_t'(cfg_if.index))
        cdls_pkg::REG_ADC_OFFSET:   cfg_nxt.adc_offset   = cfg_if.data;
        cdls_pkg::REG_CURRENT_GOAL: cfg_nxt.current_goal = goal_wr;
        cdls_pkg::REG_DEADBAND:
          cfg_nxt.deadband = cfg_if.data[cdls_pkg::DB_W-1:0];
        cdls_pkg::REG_TRIP_CURRENT: cfg_nxt.trip_current = cfg_if.data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  // per-item state update
  cdls_step #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_step (
    .cur            (st_r),
    .cfg            (cfg_r),
    .action         (cdls_pkg::action_t'(in_if.action)),
    .sample         (in_if.sample),
    .resonance_idle (in_if.resonance_idle),
    .new_level      (in_if.new_level),
    .mode           (in_if.mode),
    .nxt            (st_nxt),
    .changed        (changed_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_offset   <= cdls_pkg::OFFSET_RST;
      cfg_r.current_goal <= cdls_pkg::GOAL_RST;
      cfg_r.deadband     <= cdls_pkg::DEADBAND_RST;
      cfg_r.trip_current <= cdls_pkg::TRIP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.present  <= '0;
      st_r.filtered <= '0;
      st_r.level    <= cdls_pkg::LEVEL_RST;
      st_r.auto_on  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      // output register holds while stalled, reloads on every accept
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // change flag of the pending result, only read while out_valid_r is set
  always_ff @(posedge clk) begin
    if (in_fire) begin
      changed_r <= changed_nxt;
    end
  end

  // result fields mirror the state left by the last accepted item
  assign out_if.valid            = out_valid_r;
  assign out_if.filtered_current = st_r.filtered;
  assign out_if.present_current  = st_r.present;
  assign out_if.level            = st_r.level;
  assign out_if.level_changed    = changed_r;
  assign out_if.auto_on          = st_r.auto_on;

`ifndef SYNTHESIS
  // level stays within the saturation limit or the protection value
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.level <= cdls_pkg::LEVEL_W'(LEVEL_MAX)) ||
    (st_r.level <= cdls_pkg::LEVEL_PROT_VAL))
    else $error("level above limit");

  // every accepted item produces a pending result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item without result");

  // samples and mode writes never report a level change
  a_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ((in_if.action == cdls_pkg::ACT_SAMPLE) ||
                (in_if.action == cdls_pkg::ACT_SET_MODE)) |=> !changed_r)
    else $error("level change flagged on sample or mode item");

  // overcurrent on a control step drops auto mode
  a_trip: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_if.action == cdls_pkg::ACT_STEP) &&
    (st_r.present > cfg_r.trip_current) |=> !st_r.auto_on)
    else $error("auto mode survived trip");
`endif

endmodule

@@ test/level_stepper_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_stepper_checker
// Watches the item, result and register channels of the current stepper,
// predicts every result from its own copy of the state and settings, and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module level_stepper_checker
  import cdls_pkg::*;
#(
  parameter int unsigned LEVEL_MAX = 235
) (
  input  logic        clk,
  input  logic        rst_n,
  cdls_in_if          in_ch,
  cdls_out_if         out_ch,
  cdls_cfg_if         cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned MAX_SHOWN = 100;

  typedef struct packed {
    logic [CUR_W-1:0]   filtered;
    logic [CUR_W-1:0]   present;
    logic [LEVEL_W-1:0] level;
    logic               changed;
    logic               auto_on;
  } reading_t;

  cfg_t        regs;
  state_t      plant;
  reading_t    readings_q[$];
  int unsigned fails = 0;
  int unsigned shown = 0;

  // next state and reading of the current loop after one item
  function automatic reading_t control_update(input cfg_t c, input state_t s,
                                              input action_t act,
                                              input logic [CUR_W-1:0] smp,
                                              input logic idle,
                                              input logic [LEVEL_W-1:0] nl,
                                              input logic md,
                                              output state_t nxt);
    reading_t    r;
    int unsigned mixed;
    int          hi;
    int          lo;
    logic        chg;
    nxt = s;
    chg = 1'b0;
    case (act)
      ACT_SAMPLE: begin
        nxt.present = (smp > c.adc_offset) ? smp - c.adc_offset : '0;
        mixed = (32'(nxt.present) * 32'd10 + 32'(s.filtered) * 32'd70) / 32'd80;
        nxt.filtered = mixed[CUR_W-1:0];
      end
      ACT_STEP: begin
        if (s.present > c.trip_current) nxt.auto_on = 1'b0;
        if (nxt.level > LEVEL_PROT_LIM) begin
          nxt.level = LEVEL_PROT_VAL;
          chg = 1'b1;
        end
        if (nxt.auto_on && idle) begin
          hi = int'(c.current_goal) + int'(c.deadband);
          lo = int'(c.current_goal) - int'(c.deadband);
          if (int'(nxt.present) > hi) begin
            if (nxt.level != '0) nxt.level = nxt.level - 1'b1;
            chg = 1'b1;
          end else if (int'(nxt.present) <= lo) begin
            if (nxt.level < LEVEL_W'(LEVEL_MAX)) nxt.level = nxt.level + 1'b1;
            chg = 1'b1;
          end
        end
      end
      ACT_SET_LEVEL: begin
        nxt.level = (nl > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : nl;
        chg = 1'b1;
      end
      default: begin
        nxt.auto_on = md;
      end
    endcase
    r = '{filtered: nxt.filtered, present: nxt.present, level: nxt.level,
          changed: chg, auto_on: nxt.auto_on};
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fails++;
      if (shown < MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      shown++;
    end
  endtask

  always @(posedge clk) begin : track
    reading_t         want;
    state_t           nxt;
    logic [GOAL_W-1:0] goal;
    if (!rst_n) begin
      regs = '{adc_offset: OFFSET_RST, current_goal: GOAL_RST,
               deadband: DEADBAND_RST, trip_current: TRIP_RST};
      plant = '{present: '0, filtered: '0, level: LEVEL_RST, auto_on: 1'b0};
      readings_q.delete();
    end else begin
      // results first, so a result can never meet its own prediction early
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (readings_q.size() == 0) begin
          fails++;
          if (shown < MAX_SHOWN)
            $display("%0t: result with no prediction waiting, expected none, actual %0d/%0d/%0d/%0d/%0d",
                     $time, out_ch.filtered_current, out_ch.present_current,
                     out_ch.level, out_ch.level_changed, out_ch.auto_on);
          shown++;
        end else begin
          want = readings_q.pop_front();
          check_field("filtered_current", want.filtered, out_ch.filtered_current);
          check_field("present_current", want.present, out_ch.present_current);
          check_field("level", want.level, out_ch.level);
          check_field("level_changed", want.changed, out_ch.level_changed);
          check_field("auto_on", want.auto_on, out_ch.auto_on);
        end
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.index)
          REG_ADC_OFFSET: regs.adc_offset = cfg_ch.data[CUR_W-1:0];
          REG_CURRENT_GOAL: begin
            goal = cfg_ch.data[GOAL_W-1:0];
            if (goal < GOAL_MIN) goal = GOAL_MIN;
            else if (goal > GOAL_MAX) goal = GOAL_MAX;
            regs.current_goal = goal;
          end
          REG_DEADBAND: regs.deadband = cfg_ch.data[DB_W-1:0];
          REG_TRIP_CURRENT: regs.trip_current = cfg_ch.data[CUR_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        want = control_update(regs, plant, action_t'(in_ch.action), in_ch.sample,
                              in_ch.resonance_idle, in_ch.new_level, in_ch.mode, nxt);
        plant = nxt;
        readings_q.push_back(want);
      end
    end
    pending    <= readings_q.size();
    fail_count <= fails;
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the current stepper with directed and shaped random items under
// several register settings, with bursty input and a stalling receiver; the
// checker beside the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import cdls_pkg::*;

  localparam int unsigned LEVEL_TOP     = 235;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;     // block output is registered
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned HOLD_AFTER    = 150;   // results seen before it
  localparam int unsigned PHASE_ITEMS   = 88;

  logic clk = 1'b0;
  logic rst_n;

  cdls_in_if  in_if ();
  cdls_out_if out_if ();
  cdls_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;

  // stimulus-side view of the settings, only used to aim samples at the band
  int offset_now;
  int goal_now;
  int db_now;
  int trip_now;

  // sender burst state
  int unsigned burst_left = 0;
  bit          offering   = 1'b0;

  always #4 clk = ~clk;

  current_deadband_level_stepper #(
    .LEVEL_MAX(LEVEL_TOP)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  level_stepper_checker #(
    .LEVEL_MAX(LEVEL_TOP)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_ch     (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: stall rate changes per window, plus one long hold-off once
  // enough results have gone by, so the output register fills and the block
  // has to stall its input while the sender keeps offering
  initial begin : receiver
    int unsigned window;
    int unsigned stall_pct;
    int unsigned hold_left;
    int unsigned taken;
    bit          held;
    window    = 0;
    stall_pct = 0;
    hold_left = 0;
    taken     = 0;
    held      = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) taken++;
      if (!held && taken == HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (window == 0) begin
        window = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      window--;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // one item transaction; arg is the field the action uses, the other
  // fields get random bits so every input bit toggles
  task automatic push_item(input action_t act, input int unsigned arg);
    if (burst_left == 0) begin
      if (offering) begin
        in_if.valid <= 1'b0;
        offering = 1'b0;
      end
      // a gap always comes first, so valid never drops and rises in one step
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
    in_if.action         <= act;
    in_if.sample         <= (act == ACT_SAMPLE)    ? CUR_W'(arg)   : CUR_W'($urandom);
    in_if.resonance_idle <= (act == ACT_STEP)      ? arg[0]        : 1'($urandom);
    in_if.new_level      <= (act == ACT_SET_LEVEL) ? LEVEL_W'(arg) : LEVEL_W'($urandom);
    in_if.mode           <= (act == ACT_SET_MODE)  ? arg[0]        : 1'($urandom);
    in_if.valid          <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    burst_left--;
  endtask

  // stop offering; the next item starts a fresh burst after a gap
  task automatic hold_input();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
  endtask

  // wait until every predicted result has come back, then let the pipe settle
  task automatic wait_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back, optionally followed by an
  // index the block must drop
  task automatic write_settings(input int off, input int goal, input int db,
                                input int trip, input bit with_junk);
    logic [IDX_W-1:0]  idx [5];
    logic [DATA_W-1:0] dat [5];
    int unsigned       n;
    idx[0] = REG_ADC_OFFSET;   dat[0] = DATA_W'(off);
    idx[1] = REG_CURRENT_GOAL; dat[1] = DATA_W'(goal);
    idx[2] = REG_DEADBAND;     dat[2] = DATA_W'(db);
    idx[3] = REG_TRIP_CURRENT; dat[3] = DATA_W'(trip);
    idx[4] = IDX_W'($urandom_range(4, 255));
    dat[4] = DATA_W'($urandom);
    n = with_junk ? 5 : 4;
    offset_now = off & 16'hFFFF;
    goal_now   = goal & 16'h3FFF;
    if (goal_now < int'(GOAL_MIN)) goal_now = int'(GOAL_MIN);
    if (goal_now > int'(GOAL_MAX)) goal_now = int'(GOAL_MAX);
    db_now     = db & 16'h0FFF;
    trip_now   = trip & 16'hFFFF;
    cfg_if.valid <= 1'b1;
    for (int k = 0; k < n; k++) begin
      cfg_if.index <= idx[k];
      cfg_if.data  <= dat[k];
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // raw readings aimed at the band edges, the trip level and the offset
  function automatic int unsigned pick_sample();
    int t;
    case ($urandom_range(0, 7))
      0:       t = int'($urandom_range(0, 65535));
      1:       t = offset_now - int'($urandom_range(0, 40));
      2, 3:    t = offset_now + goal_now + db_now + int'($urandom_range(0, 4)) - 2;
      4, 5:    t = offset_now + goal_now - db_now + int'($urandom_range(0, 4)) - 2;
      6:       t = offset_now + goal_now + int'($urandom_range(0, 2 * db_now)) - db_now;
      default: t = offset_now + trip_now + int'($urandom_range(0, 4)) - 2;
    endcase
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return t;
  endfunction

  // manual levels around the protection limit and the ends of the range
  function automatic int unsigned pick_level();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 255);
      1:       return $urandom_range(214, 240);
      2:       return $urandom_range(0, 3);
      default: return $urandom_range(250, 255);
    endcase
  endfunction

  // mostly samples and control steps with auto mode kept on, so the level
  // keeps walking up and down; manual levels and mode drops as noise
  task automatic run_random(input int unsigned n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) push_item(ACT_SAMPLE, pick_sample());
      else if (roll < 75) push_item(ACT_STEP, ($urandom_range(0, 9) != 0));
      else if (roll < 85) push_item(ACT_SET_LEVEL, pick_level());
      else push_item(ACT_SET_MODE, ($urandom_range(0, 4) != 0));
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.action         <= ACT_SAMPLE;
    in_if.sample         <= '0;
    in_if.resonance_idle <= 1'b0;
    in_if.new_level      <= '0;
    in_if.mode           <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    offset_now = int'(OFFSET_RST);
    goal_now   = int'(GOAL_RST);
    db_now     = int'(DEADBAND_RST);
    trip_now   = int'(TRIP_RST);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: band 700..1300, trip 10500
    push_item(ACT_SAMPLE, 0);          // zero reading
    push_item(ACT_SAMPLE, 65535);      // full-scale reading
    push_item(ACT_STEP, 1);            // auto off, nothing moves
    push_item(ACT_SET_MODE, 1);
    push_item(ACT_STEP, 1);            // current above trip drops auto mode
    push_item(ACT_SET_LEVEL, 255);     // manual level saturates at the max
    push_item(ACT_SET_MODE, 1);
    push_item(ACT_SAMPLE, 1000);       // inside the band
    push_item(ACT_STEP, 1);            // level above protect limit forced low
    push_item(ACT_SAMPLE, 1301);       // just above goal plus deadband
    push_item(ACT_STEP, 0);            // resonance busy, no step
    push_item(ACT_STEP, 1);            // step down
    push_item(ACT_SET_LEVEL, 0);
    push_item(ACT_STEP, 1);            // step down blocked at zero, still rewritten
    push_item(ACT_SAMPLE, 700);        // exactly goal minus deadband
    push_item(ACT_STEP, 1);            // step up
    push_item(ACT_SET_LEVEL, 221);
    push_item(ACT_STEP, 1);            // forced low, then still stepped up
    push_item(ACT_SET_LEVEL, 220);
    push_item(ACT_STEP, 1);            // protect limit itself is not forced
    push_item(ACT_SAMPLE, 10501);
    push_item(ACT_STEP, 1);            // trip and protection in the same step
    push_item(ACT_SET_MODE, 0);

    // directed, goal below deadband and readings not above the offset
    hold_input();
    wait_drain();
    write_settings(2000, 300, 400, 10500, 1'b0);
    push_item(ACT_SET_MODE, 1);
    push_item(ACT_SAMPLE, 1500);       // below offset, current floors at zero
    push_item(ACT_STEP, 1);            // negative lower edge, no step up
    run_random(100);

    // register settings, extremes first
    hold_input();
    wait_drain();
    write_settings(16'hFFFF, 0, 4095, 16'hFFFF, 1'b1);
    run_random(PHASE_ITEMS);

    hold_input();
    wait_drain();
    write_settings(0, 16'hFFFF, 0, 0, 1'b0);      // goal clamps high, trip at zero
    run_random(PHASE_ITEMS);

    hold_input();
    wait_drain();
    write_settings($urandom_range(0, 3000), $urandom_range(0, 16383),
                   $urandom_range(0, 800), $urandom_range(8000, 40000), 1'b1);
    run_random(PHASE_ITEMS);

    hold_input();
    wait_drain();
    write_settings(1000, 299, 300, 10500, 1'b0);  // goal clamps low
    run_random(PHASE_ITEMS);

    hold_input();
    wait_drain();
    // upper data bits beyond the goal field must be dropped
    write_settings($urandom_range(0, 500), 16'h4000 | 1000, 150, 12000, 1'b1);
    run_random(PHASE_ITEMS);

    hold_input();
    wait_drain();
    write_settings(0, 1000, 300, 10500, 1'b0);
    run_random(PHASE_ITEMS);

    hold_input();
    wait_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cdls_pkg.sv
rtl/cdls_if.sv
rtl/cdls_step.sv
rtl/current_deadband_level_stepper.sv
test/level_stepper_checker.sv
test/tb_top.sv
